### sv/assert_macros.svh
// Assertion macros shared by the frame store RTL.
// Depends on nothing; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property checked on every rising clock edge outside of reset.
`define PFB_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pfb assertion failed");

// Condition that must never hold outside of reset.
`define PFB_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pfb forbidden condition seen");

`endif

### sv/pfb_pkg.sv
// Package for the page frame buffer line plotter: request and result types,
// default geometry and the controller state encoding. Depends on nothing.
package pfb_pkg;

  // Default store geometry.
  localparam int DefColumns = 128;
  localparam int DefPages   = 8;

  // Operation codes of a request.
  localparam logic OpHorizontal = 1'b0;
  localparam logic OpVertical   = 1'b1;

  // One line drawing request.
  typedef struct packed {
    logic       op;
    logic [6:0] pos_start;
    logic [6:0] pos_end;
    logic [6:0] pos_fixed;
    logic       color;
  } req_t;

  // One result carrying up to eight updated store bytes.
  typedef struct packed {
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic [6:0]  first_column;
    logic [2:0]  first_page;
    logic        is_last;
    logic        rejected;
  } res_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StRun   = 4'b0100,
    StWait  = 4'b1000
  } state_e;

  // Set or clear the masked bits of a store byte.
  function automatic logic [7:0] apply_color(logic [7:0] data, logic [7:0] mask,
                                             logic color);
    apply_color = color ? (data | mask) : (data & ~mask);
  endfunction

endpackage

### sv/page_framebuffer_line_plotter.sv
// Top level of the page frame buffer line plotter: frame store memory,
// read-modify-write pipeline and result packing. Depends on pfb_pkg and
// assert_macros.svh.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start, busy          req_i   (pfb_pkg::req_t)
//   result    out        res_valid_o strobe   res_o   (pfb_pkg::res_t)
//
// An accepted line request keeps busy high from the moment it is taken through
// the Run and Wait states: one memory read is issued per cycle and each byte is
// modified and written back in the cycle after its read, limited by the single
// read and write port of the frame store. A rejected request gives its result
// in the next cycle and does not raise busy. After reset a clearing pass
// writes zero to every entry, PAGES * 2**clog2(COLUMNS) entries (1024 by
// default), with busy high. Results are shown for one cycle and never stall.
`include "assert_macros.svh"

module page_framebuffer_line_plotter #(
  parameter int COLUMNS = pfb_pkg::DefColumns,
  parameter int PAGES   = pfb_pkg::DefPages
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfb_pkg::req_t req_i,
  output logic          res_valid_o,
  output pfb_pkg::res_t res_o
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW    = PW + CW;
  localparam int DEPTH = PAGES * (2 ** CW);
  localparam logic [7:0] RowLim = 8'(8 * PAGES);
  localparam logic [7:0] ColLim = 8'(COLUMNS);

  // Frame store and its registered read data.
  logic [7:0] mem_q [DEPTH];
  logic [7:0] mem_rdata_q;

  pfb_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;

  // Line context captured when a request is taken.
  logic       op_q, color_q;
  logic [6:0] fixed_q, idx_q, end_q, first_q;
  logic [7:0] base_q, mstart_q, mend_q;

  // Read stage, registered from the issue point.
  logic       rd_vld_q, rd_last_q;
  logic [6:0] rd_idx_q;
  logic [7:0] rd_mask_q;
  logic [AW-1:0] rd_addr_q;

  // Packing state.
  logic [2:0]  cnt_q;
  logic [63:0] pack_q;
  logic [6:0]  pcol_q;
  logic [2:0]  ppage_q;

  logic          res_valid_q;
  pfb_pkg::res_t res_q;

  // Request check.
  logic       accept, reject;
  logic [7:0] along_lim, fixed_lim;

  assign accept    = start && !busy;
  assign along_lim = (req_i.op == pfb_pkg::OpVertical) ? RowLim : ColLim;
  assign fixed_lim = (req_i.op == pfb_pkg::OpVertical) ? ColLim : RowLim;
  assign reject    = (req_i.pos_end < req_i.pos_start)
                  || ({1'b0, req_i.pos_end} >= along_lim)
                  || ({1'b0, req_i.pos_fixed} >= fixed_lim);

  // Issue side: address and mask of the byte read this cycle.
  logic [3:0]    fixed_page;
  logic [AW-1:0] iss_addr;
  logic [7:0]    iss_mask;
  logic          iss_last, issue;

  assign fixed_page = fixed_q[6:3];
  assign iss_addr   = (op_q == pfb_pkg::OpVertical)
                    ? {idx_q[PW-1:0], fixed_q[CW-1:0]}
                    : {fixed_page[PW-1:0], idx_q[CW-1:0]};
  assign iss_last   = (idx_q == end_q);
  assign iss_mask   = base_q
                    & ((idx_q == first_q) ? mstart_q : 8'hFF)
                    & (iss_last ? mend_q : 8'hFF);
  assign issue      = (state_q == pfb_pkg::StRun);

  // Modify side: new byte value, packing and result formation.
  logic [7:0]  new_byte;
  logic [63:0] pack_now;
  logic [6:0]  cur_col;
  logic [2:0]  cur_page;
  logic        emit;

  assign new_byte = pfb_pkg::apply_color(mem_rdata_q, rd_mask_q, color_q);
  assign pack_now = ((cnt_q == 3'd0) ? 64'd0 : pack_q)
                  | (64'(new_byte) << {cnt_q, 3'b000});
  assign cur_col  = (op_q == pfb_pkg::OpVertical) ? fixed_q : rd_idx_q;
  assign cur_page = (op_q == pfb_pkg::OpVertical) ? rd_idx_q[2:0] : fixed_q[5:3];
  assign emit     = rd_vld_q && ((cnt_q == 3'd7) || rd_last_q);

  // Controller next state.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      pfb_pkg::StClear: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = pfb_pkg::StIdle;
        end
      end
      pfb_pkg::StIdle: begin
        if (accept && !reject) begin
          state_d = pfb_pkg::StRun;
        end
      end
      pfb_pkg::StRun: begin
        if (iss_last) begin
          state_d = pfb_pkg::StWait;
        end
      end
      pfb_pkg::StWait: begin
        state_d = pfb_pkg::StIdle;
      end
      default: begin
        state_d = pfb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfb_pkg::StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign busy = (state_q != pfb_pkg::StIdle);

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (state_q == pfb_pkg::StClear) begin
      mem_q[clr_q] <= 8'h00;
    end else if (rd_vld_q) begin
      mem_q[rd_addr_q] <= new_byte;
    end
    if (issue) begin
      mem_rdata_q <= mem_q[iss_addr];
    end
  end

  // Line context, loaded on an accepted request and advanced per issued read.
  always_ff @(posedge clk_i) begin
    if (accept && !reject) begin
      op_q    <= req_i.op;
      color_q <= req_i.color;
      fixed_q <= req_i.pos_fixed;
      if (req_i.op == pfb_pkg::OpVertical) begin
        idx_q    <= {3'b000, req_i.pos_start[6:3]};
        first_q  <= {3'b000, req_i.pos_start[6:3]};
        end_q    <= {3'b000, req_i.pos_end[6:3]};
        base_q   <= 8'hFF;
        mstart_q <= 8'hFF << req_i.pos_start[2:0];
        mend_q   <= 8'hFF >> (3'd7 - req_i.pos_end[2:0]);
      end else begin
        idx_q    <= req_i.pos_start;
        first_q  <= req_i.pos_start;
        end_q    <= req_i.pos_end;
        base_q   <= 8'h01 << req_i.pos_fixed[2:0];
        mstart_q <= 8'hFF;
        mend_q   <= 8'hFF;
      end
    end else if (issue) begin
      idx_q <= idx_q + 7'd1;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_last_q <= iss_last;
      rd_idx_q  <= idx_q;
      rd_mask_q <= iss_mask;
      rd_addr_q <= iss_addr;
    end
  end

  // Read stage valid and the packing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      cnt_q    <= 3'd0;
    end else begin
      rd_vld_q <= issue;
      if (emit) begin
        cnt_q <= 3'd0;
      end else if (rd_vld_q) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // Partial packet and the position of its first byte.
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      pack_q <= pack_now;
      if (cnt_q == 3'd0) begin
        pcol_q  <= cur_col;
        ppage_q <= cur_page;
      end
    end
  end

  // Result register: one strobe per finished packet or rejected request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= emit || (accept && reject);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q.packed_bytes <= pack_now;
      res_q.byte_count   <= {1'b0, cnt_q} + 4'd1;
      res_q.first_column <= (cnt_q == 3'd0) ? cur_col : pcol_q;
      res_q.first_page   <= (cnt_q == 3'd0) ? cur_page : ppage_q;
      res_q.is_last      <= rd_last_q;
      res_q.rejected     <= 1'b0;
    end else if (accept && reject) begin
      res_q.packed_bytes <= 64'd0;
      res_q.byte_count   <= 4'd0;
      res_q.first_column <= 7'd0;
      res_q.first_page   <= 3'd0;
      res_q.is_last      <= 1'b1;
      res_q.rejected     <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The read stage only carries a byte while a line is in progress.
  `PFB_ASSERT(a_rd_in_line, clk_i, rst_ni,
              rd_vld_q |-> (state_q == pfb_pkg::StRun || state_q == pfb_pkg::StWait))
  // No result leaves while the store is being cleared.
  `PFB_ASSERT_NEVER(a_no_res_clear, clk_i, rst_ni,
                    res_valid_o && state_q == pfb_pkg::StClear)
  // A rejected result is the last and carries no bytes.
  `PFB_ASSERT(a_reject_shape, clk_i, rst_ni,
              res_valid_o && res_o.rejected |-> res_o.is_last && res_o.byte_count == 4'd0)
  // An accepted result carries one to eight bytes.
  `PFB_ASSERT(a_count_range, clk_i, rst_ni,
              res_valid_o && !res_o.rejected |->
                res_o.byte_count != 4'd0 && res_o.byte_count <= 4'd8)
  // The last byte of a line always closes a packet and returns to idle.
  `PFB_ASSERT(a_last_closes, clk_i, rst_ni,
              rd_vld_q && rd_last_q |=> res_valid_o && res_o.is_last && !busy)

endmodule
